### hw/rtl/lcgsw_pkg.sv
// package for the lcg shuffle word scrambler
// holds generator constants, the generator step function and control types
// no dependencies
`default_nettype none

package lcgsw_pkg;

  localparam logic [31:0] LCG_MULT  = 32'd1664525;
  localparam logic [31:0] LCG_INC   = 32'd1013904223;
  localparam int unsigned SEL_SHIFT = 30;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned IDX_W  = 2;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [IDX_W-1:0]  idx_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_FILL = 3'b010,
    S_WORD = 3'b100
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;     // latch the input item
    logic first;      // accepted item starts a sector
    logic step_fill;  // one generator step into the table
    idx_t fill_idx;   // table entry written by a fill step
    logic step_word;  // word step, result goes to the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;   // output register can take a result this cycle
  } status_t;

  function automatic word_t lcg_next(input word_t g);
    word_t prod;
    prod = LCG_MULT * g;
    return prod + LCG_INC;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/lcg_shuffle_word_scrambler.sv
// lcg shuffle word scrambler: a plain word is accepted, then scrambled in a word step;
// a first-of-sector word has seed load plus four table fill steps before its word step
// a new item is taken only once the last word step is done, and that step waits for a
// free output register; the single generator multiply-add serves fill and word steps
// synchronous active-high reset clears generator and shuffle table to zero and empties
// the output register
`default_nettype none

module lcg_shuffle_word_scrambler (
  input  wire logic        clk,
  input  wire logic        rst,
  // input items
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        first_word,
  input  wire logic [31:0] sector_seed,
  input  wire logic [31:0] data_word,
  // result items
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      scrambled_word
);

  // command and status between controller and datapath
  lcgsw_pkg::cmd_t    cmd;
  lcgsw_pkg::status_t status;

  // controller: idle, table fill (entry 3 down to 0), word step
  lcgsw_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .first_word (first_word),
    .in_ready   (in_ready),
    .status     (status),
    .cmd        (cmd)
  );

  // datapath: generator, shuffle table and output register
  // the output register lets the next item enter while a result waits
  lcgsw_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .sector_seed    (sector_seed),
    .data_word      (data_word),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .scrambled_word (scrambled_word)
  );

endmodule

`default_nettype wire

### hw/rtl/lcgsw_ctrl.sv
// controller state machine for the lcg shuffle word scrambler
// sequences table fill and word steps; uses lcgsw_pkg
`default_nettype none

module lcgsw_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              first_word,
  output logic                   in_ready,
  input  wire lcgsw_pkg::status_t status,
  output lcgsw_pkg::cmd_t        cmd
);

  lcgsw_pkg::state_t state, state_next;
  lcgsw_pkg::idx_t   fill_idx, fill_idx_next;

  logic accept;

  assign in_ready = (state == lcgsw_pkg::S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next    = state;
    fill_idx_next = fill_idx;
    cmd           = '0;
    cmd.fill_idx  = fill_idx;
    case (state)
      lcgsw_pkg::S_IDLE: begin
        if (accept) begin
          cmd.accept = 1'b1;
          cmd.first  = first_word;
          if (first_word) begin
            fill_idx_next = '1;
            state_next    = lcgsw_pkg::S_FILL;
          end else begin
            state_next = lcgsw_pkg::S_WORD;
          end
        end
      end
      lcgsw_pkg::S_FILL: begin
        cmd.step_fill = 1'b1;
        fill_idx_next = fill_idx - 1'b1;
        if (fill_idx == '0) begin
          state_next = lcgsw_pkg::S_WORD;
        end
      end
      lcgsw_pkg::S_WORD: begin
        // wait here until the output register is free
        if (status.out_free) begin
          cmd.step_word = 1'b1;
          state_next    = lcgsw_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = lcgsw_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= lcgsw_pkg::S_IDLE;
      fill_idx <= '0;
    end else begin
      state    <= state_next;
      fill_idx <= fill_idx_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/lcgsw_dp.sv
// datapath for the lcg shuffle word scrambler
// generator register, shuffle table, word register and output register; uses lcgsw_pkg
`default_nettype none

module lcgsw_dp (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire lcgsw_pkg::cmd_t   cmd,
  output lcgsw_pkg::status_t     status,
  input  wire lcgsw_pkg::word_t  sector_seed,
  input  wire lcgsw_pkg::word_t  data_word,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output lcgsw_pkg::word_t       scrambled_word
);

  lcgsw_pkg::word_t gen;
  lcgsw_pkg::word_t word_reg;
  lcgsw_pkg::word_t shuf [4];

  lcgsw_pkg::word_t gen_step;
  lcgsw_pkg::idx_t  sel;

  assign gen_step = lcgsw_pkg::lcg_next(gen);
  assign sel      = lcgsw_pkg::idx_t'(gen_step >> lcgsw_pkg::SEL_SHIFT);

  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      gen     <= '0;
      shuf[0] <= '0;
      shuf[1] <= '0;
      shuf[2] <= '0;
      shuf[3] <= '0;
    end else begin
      if (cmd.accept && cmd.first) begin
        gen <= sector_seed;
      end else if (cmd.step_fill) begin
        gen                <= gen_step;
        shuf[cmd.fill_idx] <= gen_step;
      end else if (cmd.step_word) begin
        gen       <= gen_step;
        shuf[sel] <= gen_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      word_reg <= data_word;
    end
    if (cmd.step_word) begin
      scrambled_word <= word_reg ^ shuf[sel];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.step_word) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

### verif/tb_top.sv
// self-checking testbench for lcg_shuffle_word_scrambler: directed and random sector streams
// with a word-level scramble predictor, random idling on both sides and output back-pressure
// depends on every file in hw/rtl: package, top level, controller and datapath
`default_nettype none

module tb_top;

  // generous bound on the run: ~1800 items, sector starts and long gaps included
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned MAX_REPORTS = 10;
  // drain time after the last result, so that an unexpected extra result is still seen
  localparam int unsigned TAIL_CYCLES = 12;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  in_valid = 1'b0;
  logic  first_word = 1'b0;
  lcgsw_pkg::word_t sector_seed = '0;
  lcgsw_pkg::word_t data_word = '0;
  logic  out_ready = 1'b0;
  wire   in_ready;
  wire   out_valid;
  wire [31:0] scrambled_word;

  lcg_shuffle_word_scrambler DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .first_word     (first_word),
    .sector_seed    (sector_seed),
    .data_word      (data_word),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .scrambled_word (scrambled_word)
  );

  // predictor state: generator value and shuffle table, as after reset
  lcgsw_pkg::word_t gen_value;
  lcgsw_pkg::word_t shuffle_tbl [4];
  lcgsw_pkg::word_t scrambled_exp_q [$];

  int unsigned fail_cnt = 0;
  int unsigned cycle_cnt = 0;

  // idle percentages for each side, changed per phase
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  // receiver hold-off request, picked up and counted down by the receiver process
  int unsigned hold_req = 0;
  int unsigned hold_left = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  // one linear congruential step, modulo 2^32
  function automatic lcgsw_pkg::word_t advance_generator(input lcgsw_pkg::word_t g);
    lcgsw_pkg::word_t nxt;
    nxt = lcgsw_pkg::LCG_MULT * g + lcgsw_pkg::LCG_INC;
    return nxt;
  endfunction

  // predict the scrambled word for one accepted item and update the predictor state
  task automatic predict_scramble(input logic first, input lcgsw_pkg::word_t seed,
                                  input lcgsw_pkg::word_t data);
    lcgsw_pkg::word_t g;
    lcgsw_pkg::idx_t  sel;
    g = gen_value;
    // sector start: reload from the seed, fill entries 3 down to 0
    if (first) begin
      g = seed;
      for (int i = 3; i >= 0; i--) begin
        g = advance_generator(g);
        shuffle_tbl[lcgsw_pkg::idx_t'(i)] = g;
      end
    end
    // word step: top two bits pick the entry, which is used and then replaced
    g = advance_generator(g);
    sel = lcgsw_pkg::idx_t'(g >> lcgsw_pkg::SEL_SHIFT);
    scrambled_exp_q.push_back(data ^ shuffle_tbl[sel]);
    shuffle_tbl[sel] = g;
    gen_value = g;
  endtask

  function automatic void note_failure(input string msg);
    fail_cnt++;
    if (fail_cnt <= MAX_REPORTS) $display("tb: error at cycle %0d: %s", cycle_cnt, msg);
  endfunction

  // data with extra weight on the all-zero and all-one words
  function automatic lcgsw_pkg::word_t pick_data();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // offer one item, with random idle cycles first, and wait for it to be taken
  task automatic send_item(input logic first, input lcgsw_pkg::word_t seed,
                           input lcgsw_pkg::word_t data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    first_word  <= first;
    sector_seed <= seed;
    data_word   <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_scramble(first, seed, data);
  endtask

  // stop offering and wait until every predicted word has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (scrambled_exp_q.size() != 0) @(posedge clk);
  endtask

  // receiver side: result check, ready generation, cycle limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (!rst && out_valid && out_ready) begin
      if (scrambled_exp_q.size() == 0) begin
        note_failure($sformatf("unexpected result %08h", scrambled_word));
      end else begin
        lcgsw_pkg::word_t exp_word;
        exp_word = scrambled_exp_q.pop_front();
        if (scrambled_word !== exp_word)
          note_failure($sformatf("scrambled_word expected %08h actual %08h",
                                 exp_word, scrambled_word));
      end
    end
    // a pending hold-off request starts a long stretch with ready low
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // words before any sector start run from the reset state, seed is ignored
  task automatic test_pre_sector_words();
    send_item(1'b0, $urandom, '0);
    send_item(1'b0, '1, '1);
    send_item(1'b0, $urandom, $urandom);
  endtask

  // seed extremes, data extremes, one-word sectors back to back, seed without the flag
  task automatic test_seed_extremes();
    send_item(1'b1, '0, '0);
    send_item(1'b0, '1, '1);
    send_item(1'b0, '0, 32'h8000_0001);
    send_item(1'b1, '1, '1);
    send_item(1'b0, '0, '0);
    send_item(1'b1, 32'h0000_0001, 32'hA5A5_A5A5);
    send_item(1'b1, 32'h8000_0000, 32'h5A5A_5A5A);
    send_item(1'b1, 32'h7FFF_FFFF, '1);
    // same seed again restarts the identical key stream
    send_item(1'b1, 32'h7FFF_FFFF, '1);
    for (int i = 0; i < 6; i++) send_item(1'b0, $urandom, pick_data());
  endtask

  // random sectors, mostly short, a few long, sometimes restarting on the previous seed
  task automatic test_random_sectors(input int unsigned n_items, input int unsigned s_pct,
                                     input int unsigned r_pct);
    int unsigned      sent;
    int unsigned      len;
    lcgsw_pkg::word_t seed;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    sent = 0;
    seed = $urandom;
    while (sent < n_items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(64, 17) : $urandom_range(16, 1);
      if ($urandom_range(19) != 0) seed = $urandom;
      for (int unsigned i = 0; i < len && sent < n_items; i++) begin
        send_item(i == 0, (i == 0) ? seed : lcgsw_pkg::word_t'($urandom), pick_data());
        sent++;
      end
    end
    wait_drained();
  endtask

  // receiver stalls for a long stretch while items keep coming, input must back up
  task automatic test_output_hold_off();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 300;
    send_item(1'b1, $urandom, pick_data());
    for (int i = 0; i < 29; i++) send_item($urandom_range(7) == 0, $urandom, pick_data());
    wait_drained();
  endtask

  // sender pauses until all results are out, then resumes mid-sector
  task automatic test_sender_pause();
    send_idle_pct = 10;
    recv_idle_pct = 10;
    send_item(1'b1, $urandom, pick_data());
    for (int i = 0; i < 4; i++) send_item(1'b0, $urandom, pick_data());
    wait_drained();
    for (int i = 0; i < 5; i++) send_item(1'b0, $urandom, pick_data());
    wait_drained();
  endtask

  initial begin
    gen_value = '0;
    shuffle_tbl[0] = '0;
    shuffle_tbl[1] = '0;
    shuffle_tbl[2] = '0;
    shuffle_tbl[3] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_pre_sector_words();
    test_seed_extremes();
    wait_drained();
    // sender idles lightly against a slow receiver, then the reverse, then full speed
    test_random_sectors(583, 22, 84);
    test_random_sectors(583, 84, 22);
    test_random_sectors(584, 0, 0);
    test_output_hold_off();
    test_sender_pause();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (scrambled_exp_q.size() != 0)
      note_failure($sformatf("%0d results never arrived", scrambled_exp_q.size()));
    if (fail_cnt == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire
